// ===== rtl/core/scpf_pkg.sv =====
package scpf_pkg;

  localparam int ByteW         = 8;
  localparam int MaxPatternDef = 32;
  localparam int NumWords      = 4;
  localparam int CfgW          = 64;
  localparam int AddrW         = 6;
  localparam int CountW        = 32;
  localparam int LenRegW       = 6;
  localparam int RegIdxW       = 3;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [ByteW-1:0]  UpperA   = 8'h41;
  localparam logic [ByteW-1:0]  UpperZ   = 8'h5A;
  localparam logic [ByteW-1:0]  CaseGap  = 8'h20;

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [RegIdxW-1:0] {
    REG_LEN   = 3'd0,
    REG_WORD0 = 3'd1,
    REG_WORD1 = 3'd2,
    REG_WORD2 = 3'd3,
    REG_WORD3 = 3'd4
  } reg_idx_e;

  // Window control handed to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Fold ASCII A-Z to a-z, leave every other byte alone
  function automatic logic [ByteW-1:0] fold_case(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= UpperA && c <= UpperZ) begin
      r = c + CaseGap;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/stream_caseless_pattern_finder.sv =====
// m_axis_tvalid rises after the input transfer that causes it: the cell row
// shifts at that transfer, then ST_CMP compares the whole row and loads the
// result register. Input is not ready in ST_CMP, so a text byte holds the
// input through the compare; start items and bytes after the result do not.
// A stalled earlier result holds ST_CMP until that result transfers.
// Reset (rst_ni, asynchronous, active low) clears registers, window and state.
module stream_caseless_pattern_finder #(
  parameter int MaxPattern = scpf_pkg::MaxPatternDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]                 s_axis_tuser,   // [0] action
  input  logic                       s_axis_tlast,   // last_byte
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata,   // [0] found, [32:1] offset
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scpf_pkg::AddrW-1:0] paddr,
  input  logic [scpf_pkg::CfgW-1:0]  pwdata,
  output logic [scpf_pkg::CfgW-1:0]  prdata,
  output logic                       pready
);
  import scpf_pkg::*;

  localparam int LenW = $clog2(MaxPattern + 1);

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } state_e;

  state_e                             state_q;
  logic                               done_q;
  logic                               last_q;
  logic [CountW-1:0]                  count_q;
  logic                               out_valid_q;
  logic                               found_q;
  logic [CountW-1:0]                  offset_q;

  logic [LenRegW-1:0]                 len_q;
  logic [NumWords-1:0][CfgW-1:0]      words_q;

  logic                               in_fire;
  logic                               cfg_we;
  reg_idx_e                           reg_idx;
  logic [LenW-1:0]                    len_eff;
  logic                               zero_len;
  cell_ctrl_t                         cell_ctrl;
  logic [MaxPattern-1:0][ByteW-1:0]   pat;
  logic [MaxPattern-1:0]              pat_en;
  logic [MaxPattern:0][ByteW-1:0]     chain;
  logic [MaxPattern-1:0]              match;
  logic                               hit;
  logic                               report;
  logic                               slot_busy;
  logic [CountW-1:0]                  offset_d;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:AddrW-RegIdxW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      words_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_LEN:   len_q      <= pwdata[LenRegW-1:0];
        REG_WORD0: words_q[0] <= pwdata;
        REG_WORD1: words_q[1] <= pwdata;
        REG_WORD2: words_q[2] <= pwdata;
        REG_WORD3: words_q[3] <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEN:   prdata = {{(CfgW-LenRegW){1'b0}}, len_q};
      REG_WORD0: prdata = words_q[0];
      REG_WORD1: prdata = words_q[1];
      REG_WORD2: prdata = words_q[2];
      REG_WORD3: prdata = words_q[3];
      default:   prdata = '0;
    endcase
  end

  // Clamp the pattern length to the number of cells
  assign len_eff  = (len_q > LenRegW'(MaxPattern)) ? LenW'(MaxPattern)
                                                   : LenW'(len_q);
  assign zero_len = (len_eff == '0);

  scpf_align #(
    .MaxPattern (MaxPattern),
    .LenW       (LenW)
  ) u_align (
    .words_i (words_q),
    .len_i   (len_eff),
    .pat_o   (pat),
    .en_o    (pat_en)
  );

  // Row of window cells, newest byte in cell 0
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cell_ctrl.clear = in_fire && !s_axis_tuser[0];
  assign cell_ctrl.shift = in_fire && s_axis_tuser[0] && !done_q && !zero_len;
  assign chain[0]        = fold_case(s_axis_tdata);

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    scpf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .byte_i  (chain[k]),
      .pat_i   (pat[k]),
      .en_i    (pat_en[k]),
      .byte_o  (chain[k+1]),
      .match_o (match[k])
    );
  end

  // Compare the settled window against the aligned pattern
  assign hit       = zero_len || ((count_q >= CountW'(len_eff)) && (&match));
  assign report    = hit || last_q;
  assign slot_busy = m_axis_tvalid && !m_axis_tready;
  assign offset_d  = (hit && !zero_len) ? (count_q - CountW'(len_eff)) : '0;

  // Sequencer, counter and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      offset_q    <= '0;
    end else begin
      // Load a new result, else drop the one that just transferred
      if ((state_q == ST_CMP) && report && !slot_busy) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (!s_axis_tuser[0]) begin
              count_q <= '0;
              done_q  <= 1'b0;
            end else if (!done_q) begin
              if (!zero_len && count_q != CountMax) begin
                count_q <= count_q + 1'b1;
              end
              last_q  <= s_axis_tlast;
              state_q <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          if (!report) begin
            state_q <= ST_IDLE;
          end else if (!slot_busy) begin
            found_q     <= hit;
            offset_q    <= offset_d;
            done_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, offset_q, found_q};

endmodule

// ===== rtl/core/scpf_cell.sv =====
module scpf_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scpf_pkg::cell_ctrl_t       ctrl_i,
  input  logic [scpf_pkg::ByteW-1:0] byte_i,   // from the newer neighbor
  input  logic [scpf_pkg::ByteW-1:0] pat_i,    // aligned, folded pattern byte
  input  logic                       en_i,     // cell lies inside the pattern
  output logic [scpf_pkg::ByteW-1:0] byte_o,   // to the older neighbor
  output logic                       match_o
);
  import scpf_pkg::*;

  logic [ByteW-1:0] win_q, win_d;

  // Clear on start, advance one place per text byte, else hold
  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.shift) begin
      win_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign byte_o  = win_q;
  assign match_o = !en_i || (win_q == pat_i);

endmodule

// ===== rtl/core/scpf_align.sv =====
module scpf_align #(
  parameter int MaxPattern = scpf_pkg::MaxPatternDef,
  parameter int LenW       = $clog2(MaxPattern + 1)
) (
  input  logic [scpf_pkg::NumWords*scpf_pkg::CfgW-1:0] words_i,
  input  logic [LenW-1:0]                              len_i,
  output logic [MaxPattern-1:0][scpf_pkg::ByteW-1:0]   pat_o,
  output logic [MaxPattern-1:0]                        en_o
);
  import scpf_pkg::*;

  logic [MaxPattern-1:0][ByteW-1:0] rev;
  logic [MaxPattern*ByteW-1:0]      shifted;
  logic [LenW-1:0]                  shamt;

  // Fold and reverse the pattern so its first byte sits at the top
  for (genvar m = 0; m < MaxPattern; m++) begin : g_rev
    assign rev[m] = fold_case(words_i[(MaxPattern-1-m)*ByteW +: ByteW]);
  end

  // Slide down so that cell k sees pattern byte len-1-k
  assign shamt   = LenW'(MaxPattern) - len_i;
  assign shifted = rev >> {shamt, 3'b000};
  assign pat_o   = shifted;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_en
    assign en_o[k] = (len_i > LenW'(k));
  end

endmodule

// ===== rtl/core/scpf_checker.sv =====
module scpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A start transfer never blocks the next input
  a_start_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
    else $error("input stalled after a start transfer");

  // A miss carries offset zero
  a_miss_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("miss with nonzero offset");

  // No result in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

endmodule

bind stream_caseless_pattern_finder scpf_checker u_scpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
